FILE: rtl/xdec_pkg.sv
// ----------------------------------------------------------------------------
// xdec_pkg
// Record types and the single-instruction decode function of the x86-64
// subset decoder.
// ----------------------------------------------------------------------------
package xdec_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int VIEW_BYTES = 11;

    typedef logic [VIEW_BYTES*8-1:0] t_view;

    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  sub_op;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic [63:0] immediate;
        logic [3:0]  inst_length;
    } t_rec;

    typedef struct packed {
        t_rec        rec;
        logic [15:0] start_offset;
        logic        flush_last;
    } t_item;

    typedef enum logic [1:0] {
        ACT_WAIT,
        ACT_DROP,
        ACT_EMIT
    } t_act;

    typedef struct packed {
        t_act act;
        t_rec rec;
    } t_dec;

    localparam logic [4:0] K_RET     = 5'd0;
    localparam logic [4:0] K_PUSH    = 5'd1;
    localparam logic [4:0] K_POP     = 5'd2;
    localparam logic [4:0] K_JMP     = 5'd3;
    localparam logic [4:0] K_CALL    = 5'd4;
    localparam logic [4:0] K_MOVI64  = 5'd5;
    localparam logic [4:0] K_MOVI32  = 5'd6;
    localparam logic [4:0] K_JCC     = 5'd7;
    localparam logic [4:0] K_IMUL    = 5'd8;
    localparam logic [4:0] K_MOVRR   = 5'd9;
    localparam logic [4:0] K_ADD     = 5'd10;
    localparam logic [4:0] K_SUB     = 5'd11;
    localparam logic [4:0] K_XOR     = 5'd12;
    localparam logic [4:0] K_CMP     = 5'd13;
    localparam logic [4:0] K_TEST    = 5'd14;
    localparam logic [4:0] K_GRP1I32 = 5'd15;
    localparam logic [4:0] K_GRP1I8  = 5'd16;
    localparam logic [4:0] K_SHIFT   = 5'd17;
    localparam logic [4:0] K_NEG     = 5'd18;
    localparam logic [4:0] K_IDIV    = 5'd19;
    localparam logic [4:0] K_F7OTH   = 5'd20;
    localparam logic [4:0] K_CALLRM  = 5'd21;
    localparam logic [4:0] K_PUSHRM  = 5'd22;
    localparam logic [4:0] K_FFOTH   = 5'd23;
    localparam logic [4:0] K_CQO     = 5'd24;
    localparam logic [4:0] K_MOVABS  = 5'd25;
    localparam logic [4:0] K_DB      = 5'd26;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic t_dec xdec_decode(input t_view w, input logic [4:0] n,
                                         input logic fin);
        t_dec        d;
        logic        h;
        logic        rw;
        logic        rx;
        logic        bx;
        logic [4:0]  m;
        logic [3:0]  hl;
        logic [79:0] c;
        logic [7:0]  b;
        logic [7:0]  mr;
        logic [7:0]  b2;
        logic [3:0]  reg_f;
        logic [3:0]  rm_f;
        logic        alu;
        d = '0;
        d.act = ACT_EMIT;
        if (n == 5'd0) begin
            d.act = fin ? ACT_DROP : ACT_WAIT;
            return d;
        end
        h  = (w[7:0] >= 8'h40) && (w[7:0] <= 8'h4F);
        rw = h & w[3];
        rx = h & w[2];
        bx = h & w[0];
        if (h && n < 5'd2) begin
            d.act = fin ? ACT_DROP : ACT_WAIT;
            return d;
        end
        m  = n - {4'd0, h};
        hl = {3'd0, h};
        c  = h ? w[87:8] : w[79:0];
        b  = c[7:0];
        mr = c[15:8];
        b2 = c[15:8];
        reg_f = {rx, mr[5:3]};
        rm_f  = {bx, mr[2:0]};

        if (!h) begin
            if (b == 8'hC3) begin
                d.rec.kind = K_RET;
                d.rec.inst_length = 4'd1;
                return d;
            end
            if (b >= 8'h50 && b <= 8'h5F) begin
                d.rec.dest_reg = {1'b0, b[2:0]};
                d.rec.kind = (b < 8'h58) ? K_PUSH : K_POP;
                d.rec.inst_length = 4'd1;
                return d;
            end
            if (b == 8'hE9 || b == 8'hE8) begin
                if (m >= 5'd5) begin
                    d.rec.immediate = sx32(c[39:8]) + 64'd5;
                    d.rec.kind = (b == 8'hE9) ? K_JMP : K_CALL;
                    d.rec.inst_length = 4'd5;
                    return d;
                end else if (!fin) begin
                    d.act = ACT_WAIT;
                    return d;
                end
            end
        end else if (b >= 8'h50 && b <= 8'h5F) begin
            d.rec.dest_reg = {bx, b[2:0]};
            d.rec.kind = (b < 8'h58) ? K_PUSH : K_POP;
            d.rec.inst_length = 4'd2;
            return d;
        end

        if (b == 8'hB8 && rw) begin
            if (m >= 5'd9) begin
                d.rec.dest_reg = {bx, 3'd0};
                d.rec.immediate = c[71:8];
                d.rec.kind = K_MOVI64;
                d.rec.inst_length = hl + 4'd9;
                return d;
            end else if (!fin) begin
                d.act = ACT_WAIT;
                return d;
            end
        end

        if (b == 8'hC7) begin
            if (m >= 5'd2) begin
                if (mr[7:6] == 2'b11 && reg_f == 4'd0) begin
                    if (m >= 5'd6) begin
                        d.rec.dest_reg = rm_f;
                        d.rec.immediate = sx32(c[47:16]);
                        d.rec.kind = K_MOVI32;
                        d.rec.inst_length = hl + 4'd6;
                        return d;
                    end else if (!fin) begin
                        d.act = ACT_WAIT;
                        return d;
                    end
                end
            end else if (!fin) begin
                d.act = ACT_WAIT;
                return d;
            end
        end

        if (b == 8'h0F) begin
            if (m >= 5'd2) begin
                if (b2 >= 8'h80 && b2 <= 8'h8F) begin
                    if (m >= 5'd6) begin
                        d.rec.sub_op = b2[3:0];
                        d.rec.immediate = sx32(c[47:16]) + 64'd6;
                        d.rec.kind = K_JCC;
                        d.rec.inst_length = hl + 4'd6;
                        return d;
                    end else if (!fin) begin
                        d.act = ACT_WAIT;
                        return d;
                    end
                end
                if (b2 == 8'hAF) begin
                    if (m >= 5'd3) begin
                        d.rec.dest_reg = {rx, c[21:19]};
                        d.rec.src_reg = {bx, c[18:16]};
                        d.rec.kind = K_IMUL;
                        d.rec.inst_length = hl + 4'd3;
                        return d;
                    end else if (!fin) begin
                        d.act = ACT_WAIT;
                        return d;
                    end
                end
            end else if (!fin) begin
                d.act = ACT_WAIT;
                return d;
            end
        end

        alu = (b == 8'h89) || (b == 8'h8B) || (b == 8'h01) || (b == 8'h29) ||
              (b == 8'h31) || (b == 8'h39) || (b == 8'h85) || (b == 8'h8D) ||
              (b == 8'h81) || (b == 8'h83) || (b == 8'hC1) || (b == 8'hF7) ||
              (b == 8'hFF);
        if (alu) begin
            if (m < 5'd2) begin
                d.act = fin ? ACT_DROP : ACT_WAIT;
                return d;
            end
            if (mr[7:6] == 2'b11) begin
                d.rec.dest_reg = rm_f;
                d.rec.src_reg = reg_f;
                d.rec.inst_length = hl + 4'd2;
                case (b)
                    8'h89: begin
                        d.rec.kind = K_MOVRR;
                        return d;
                    end
                    8'h8B: begin
                        d.rec.dest_reg = reg_f;
                        d.rec.src_reg = rm_f;
                        d.rec.kind = K_MOVRR;
                        return d;
                    end
                    8'h01: begin
                        d.rec.kind = K_ADD;
                        return d;
                    end
                    8'h29: begin
                        d.rec.kind = K_SUB;
                        return d;
                    end
                    8'h31: begin
                        d.rec.kind = K_XOR;
                        return d;
                    end
                    8'h39: begin
                        d.rec.kind = K_CMP;
                        return d;
                    end
                    8'h85: begin
                        d.rec.kind = K_TEST;
                        return d;
                    end
                    default: begin
                    end
                endcase
                d.rec.src_reg = 4'd0;
                d.rec.sub_op = reg_f;
                if (b == 8'h81) begin
                    if (m >= 5'd6) begin
                        d.rec.immediate = sx32(c[47:16]);
                        d.rec.kind = K_GRP1I32;
                        d.rec.inst_length = hl + 4'd6;
                        return d;
                    end else if (!fin) begin
                        d.act = ACT_WAIT;
                        return d;
                    end
                end else if (b == 8'h83 || b == 8'hC1) begin
                    if (m >= 5'd3) begin
                        if (b == 8'h83) begin
                            d.rec.immediate = {{56{c[23]}}, c[23:16]};
                            d.rec.kind = K_GRP1I8;
                        end else begin
                            d.rec.immediate = {56'd0, c[23:16]};
                            d.rec.kind = K_SHIFT;
                        end
                        d.rec.inst_length = hl + 4'd3;
                        return d;
                    end else if (!fin) begin
                        d.act = ACT_WAIT;
                        return d;
                    end
                end else if (b == 8'hF7) begin
                    d.rec.kind = (reg_f == 4'd3) ? K_NEG :
                                 ((reg_f == 4'd7) ? K_IDIV : K_F7OTH);
                    return d;
                end else if (b == 8'hFF) begin
                    d.rec.kind = (reg_f == 4'd2) ? K_CALLRM :
                                 ((reg_f == 4'd6) ? K_PUSHRM : K_FFOTH);
                    return d;
                end
                d.rec = '0;
            end
        end

        if (b == 8'h99 && rw) begin
            d.rec.kind = K_CQO;
            d.rec.inst_length = hl + 4'd1;
            return d;
        end

        if (b >= 8'hB9 && b <= 8'hBF && rw) begin
            if (m >= 5'd9) begin
                d.rec.dest_reg = {bx, b[2:0]};
                d.rec.immediate = c[71:8];
                d.rec.kind = K_MOVABS;
                d.rec.inst_length = hl + 4'd9;
                return d;
            end else if (!fin) begin
                d.act = ACT_WAIT;
                return d;
            end
        end

        d.rec = '0;
        d.rec.immediate = {56'd0, b};
        d.rec.kind = K_DB;
        d.rec.inst_length = hl + 4'd1;
        return d;
    endfunction

endpackage

FILE: rtl/x86_64_subset_instruction_decoder.sv
// Flow: a code byte is taken into the window; each record it completes is then decoded
// in turn, the batch is closed, and records pass through the queue to the output register.
// A new byte is taken only after the decode loop has closed the batch of the previous one.
// Reset: synchronous active-low; clears window fill, offset, queue and output.
// ----------------------------------------------------------------------------
// x86_64_subset_instruction_decoder
// Streaming decoder for a subset of x86-64 machine code.
// ----------------------------------------------------------------------------
module x86_64_subset_instruction_decoder #(
    parameter int MAX_CODE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_code_byte,
    input  logic        i_end_of_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_kind,
    output logic [3:0]  o_sub_op,
    output logic [3:0]  o_dest_reg,
    output logic [3:0]  o_src_reg,
    output logic signed [63:0] o_immediate,
    output logic [3:0]  o_inst_length,
    output logic [15:0] o_start_offset,
    output logic        o_flush_last
);
    import xdec_pkg::*;

    logic  push;
    t_item push_item;
    logic  push_ready;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;
    t_item out_item;

    xdec_front #(
        .MAX_CODE_BYTES(MAX_CODE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_code_byte  (i_code_byte),
        .i_end_of_code(i_end_of_code),
        .o_push       (push),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    xdec_fifo #(
        .DEPTH(4)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .o_ready(push_ready),
        .o_valid(q_valid),
        .o_item (q_item),
        .i_pop  (q_pop)
    );

    xdec_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_item     (out_item)
    );

    assign o_kind         = out_item.rec.kind;
    assign o_sub_op       = out_item.rec.sub_op;
    assign o_dest_reg     = out_item.rec.dest_reg;
    assign o_src_reg      = out_item.rec.src_reg;
    assign o_immediate    = out_item.rec.immediate;
    assign o_inst_length  = out_item.rec.inst_length;
    assign o_start_offset = out_item.start_offset;
    assign o_flush_last   = out_item.flush_last;

endmodule

FILE: rtl/xdec_front.sv
// ----------------------------------------------------------------------------
// xdec_front
// Byte window and decode loop: one record per cycle into the queue while the queue has room.
// ----------------------------------------------------------------------------
module xdec_front #(
    parameter int MAX_CODE_BYTES = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_code_byte,
    input  logic           i_end_of_code,
    output logic           o_push,
    output xdec_pkg::t_item o_push_item,
    input  logic           i_push_ready
);
    import xdec_pkg::*;

    localparam int OFW = $clog2(MAX_CODE_BYTES);
    localparam int EW  = (OFW > 16) ? OFW : 16;

    logic [7:0]     r_win [WIN_DEPTH];
    logic [4:0]     r_fill;
    logic [OFW-1:0] r_off;
    logic           r_busy;
    logic           r_fin;
    logic           r_pend_v;
    t_rec           r_pend;
    logic [15:0]    r_pend_off;

    t_view          view;
    t_dec           dec;
    logic [OFW:0]   off_sum;
    logic [OFW-1:0] n_off;
    logic [EW-1:0]  off_ext;
    logic [4:0]     wr_idx;
    logic           stall;

    always_comb begin
        for (int i = 0; i < VIEW_BYTES; i++) begin
            view[8*i +: 8] = r_win[i];
        end
    end

    assign dec     = xdec_decode(view, r_fill, r_fin);
    assign off_sum = {1'b0, r_off} + (OFW+1)'(dec.rec.inst_length);
    assign n_off   = (off_sum >= (OFW+1)'(MAX_CODE_BYTES)) ?
                     OFW'(off_sum - (OFW+1)'(MAX_CODE_BYTES)) : off_sum[OFW-1:0];
    assign off_ext = EW'(r_off);
    assign wr_idx  = (r_fill >= 5'(WIN_DEPTH)) ? 5'd0 : r_fill;
    assign stall   = r_pend_v && !i_push_ready;

    assign o_in_ready = !r_busy;
    assign o_push     = r_busy && r_pend_v;
    assign o_push_item.rec          = r_pend;
    assign o_push_item.start_offset = r_pend_off;
    assign o_push_item.flush_last   = (dec.act != ACT_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_off    <= '0;
            r_busy   <= 1'b0;
            r_fin    <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (!r_busy) begin
            if (i_in_valid) begin
                r_win[wr_idx[3:0]] <= i_code_byte;
                r_fill <= wr_idx + 5'd1;
                r_fin  <= i_end_of_code;
                r_busy <= 1'b1;
            end
        end else if (!stall) begin
            if (dec.act == ACT_EMIT) begin
                r_pend_v   <= 1'b1;
                r_pend     <= dec.rec;
                r_pend_off <= off_ext[15:0];
                r_off      <= n_off;
                r_fill     <= r_fill - {1'b0, dec.rec.inst_length};
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    if (i + int'(dec.rec.inst_length) < WIN_DEPTH) begin
                        r_win[i] <= r_win[4'(i) + dec.rec.inst_length];
                    end
                end
            end else begin
                r_pend_v <= 1'b0;
                r_busy   <= 1'b0;
                if (dec.act == ACT_DROP || r_fin) begin
                    r_fill <= '0;
                end
                if (r_fin) begin
                    r_off <= '0;
                end
            end
        end
    end

endmodule

FILE: rtl/xdec_fifo.sv
// ----------------------------------------------------------------------------
// xdec_fifo
// Short record queue between decode and output stages.
// ----------------------------------------------------------------------------
module xdec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xdec_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output xdec_pkg::t_item o_item,
    input  logic            i_pop
);
    import xdec_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

FILE: rtl/xdec_back.sv
// ----------------------------------------------------------------------------
// xdec_back
// Output register stage that presents records on the result channel.
// ----------------------------------------------------------------------------
module xdec_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  xdec_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output xdec_pkg::t_item o_item
);
    import xdec_pkg::*;

    logic  r_v;
    t_item r_item;

    assign o_pop       = i_valid && (!r_v || i_out_ready);
    assign o_out_valid = r_v;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_pop) begin
            r_v    <= 1'b1;
            r_item <= i_item;
        end else if (i_out_ready) begin
            r_v <= 1'b0;
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams random and directed x86-64 code bytes into the subset decoder and
// checks every decoded record, field by field, against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import xdec_pkg::*;

    localparam int CODE_SPAN = 65536;
    localparam int RAND_ITEMS = 180;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_code_byte = 8'd0;
    logic        i_end_of_code = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [4:0]  o_kind;
    logic [3:0]  o_sub_op;
    logic [3:0]  o_dest_reg;
    logic [3:0]  o_src_reg;
    logic signed [63:0] o_immediate;
    logic [3:0]  o_inst_length;
    logic [15:0] o_start_offset;
    logic        o_flush_last;

    x86_64_subset_instruction_decoder dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct {
        logic [7:0] code;
        logic       eoc;
    } byte_xfer_t;

    byte_xfer_t  pend_bytes[$];
    t_item       expected_recs[$];
    logic [7:0]  win[16];
    int          win_fill = 0;
    int          code_off = 0;
    int          in_count = 0;
    int          total_bytes = 0;
    int          errors = 0;
    logic        hold = 1'b0;

    function automatic logic [63:0] imm32_at(int p);
        return {{32{win[p+3][7]}}, win[p+3], win[p+2], win[p+1], win[p]};
    endfunction

    function automatic logic [63:0] imm64_at(int p);
        return {win[p+7], win[p+6], win[p+5], win[p+4],
                win[p+3], win[p+2], win[p+1], win[p]};
    endfunction

    // Returns length, 0 to drop the window, -1 to wait for more bytes.
    function automatic int decode_insn(int n, bit fin, output t_rec r);
        int         h;
        int         m;
        logic       rw;
        logic [3:0] rx;
        logic [3:0] bx;
        logic [7:0] b;
        logic [7:0] mr;
        logic [3:0] reg_n;
        logic [3:0] rm_n;
        r = '0;
        h = 0; rw = 1'b0; rx = 4'd0; bx = 4'd0;
        if (n == 0) return fin ? 0 : -1;
        if (win[0] >= 8'h40 && win[0] <= 8'h4F) begin
            rw = win[0][3];
            rx = win[0][2] ? 4'd8 : 4'd0;
            bx = win[0][0] ? 4'd8 : 4'd0;
            h = 1;
            if (n < 2) return fin ? 0 : -1;
        end
        m = n - h;
        b = win[h];
        mr = (m >= 2) ? win[h+1] : 8'd0;
        reg_n = {1'b0, mr[5:3]} | rx;
        rm_n = {1'b0, mr[2:0]} | bx;

        if (h == 0) begin
            if (b == 8'hC3) begin
                r.kind = K_RET; r.inst_length = 4'd1; return 1;
            end
            if (b >= 8'h50 && b <= 8'h5F) begin
                r.dest_reg = {1'b0, b[2:0]};
                r.kind = (b < 8'h58) ? K_PUSH : K_POP;
                r.inst_length = 4'd1;
                return 1;
            end
            if (b == 8'hE9 || b == 8'hE8) begin
                if (m >= 5) begin
                    r.immediate = imm32_at(1) + 64'd5;
                    r.kind = (b == 8'hE9) ? K_JMP : K_CALL;
                    r.inst_length = 4'd5;
                    return 5;
                end else if (!fin) return -1;
            end
        end else if (b >= 8'h50 && b <= 8'h5F) begin
            r.dest_reg = {1'b0, b[2:0]} | bx;
            r.kind = (b < 8'h58) ? K_PUSH : K_POP;
            r.inst_length = 4'd2;
            return 2;
        end

        if (b == 8'hB8 && rw) begin
            if (m >= 9) begin
                r.dest_reg = bx;
                r.immediate = imm64_at(h + 1);
                r.kind = K_MOVI64;
                r.inst_length = 4'(h + 9);
                return h + 9;
            end else if (!fin) return -1;
        end

        if (b == 8'hC7) begin
            if (m >= 2) begin
                if (mr[7:6] == 2'b11 && reg_n == 4'd0) begin
                    if (m >= 6) begin
                        r.dest_reg = rm_n;
                        r.immediate = imm32_at(h + 2);
                        r.kind = K_MOVI32;
                        r.inst_length = 4'(h + 6);
                        return h + 6;
                    end else if (!fin) return -1;
                end
            end else if (!fin) return -1;
        end

        if (b == 8'h0F) begin
            if (m >= 2) begin
                if (mr >= 8'h80 && mr <= 8'h8F) begin
                    if (m >= 6) begin
                        r.sub_op = mr[3:0];
                        r.immediate = imm32_at(h + 2) + 64'd6;
                        r.kind = K_JCC;
                        r.inst_length = 4'(h + 6);
                        return h + 6;
                    end else if (!fin) return -1;
                end
                if (mr == 8'hAF) begin
                    if (m >= 3) begin
                        r.dest_reg = {1'b0, win[h+2][5:3]} | rx;
                        r.src_reg = {1'b0, win[h+2][2:0]} | bx;
                        r.kind = K_IMUL;
                        r.inst_length = 4'(h + 3);
                        return h + 3;
                    end else if (!fin) return -1;
                end
            end else if (!fin) return -1;
        end

        if (b inside {8'h89, 8'h8B, 8'h01, 8'h29, 8'h31, 8'h39, 8'h85, 8'h8D,
                      8'h81, 8'h83, 8'hC1, 8'hF7, 8'hFF}) begin
            if (m < 2) return fin ? 0 : -1;
            if (mr[7:6] == 2'b11) begin
                r.dest_reg = rm_n;
                r.src_reg = reg_n;
                r.inst_length = 4'(h + 2);
                case (b)
                    8'h89: begin r.kind = K_MOVRR; return h + 2; end
                    8'h8B: begin
                        r.dest_reg = reg_n; r.src_reg = rm_n;
                        r.kind = K_MOVRR; return h + 2;
                    end
                    8'h01: begin r.kind = K_ADD; return h + 2; end
                    8'h29: begin r.kind = K_SUB; return h + 2; end
                    8'h31: begin r.kind = K_XOR; return h + 2; end
                    8'h39: begin r.kind = K_CMP; return h + 2; end
                    8'h85: begin r.kind = K_TEST; return h + 2; end
                    default: begin
                    end
                endcase
                r.src_reg = 4'd0;
                r.sub_op = reg_n;
                if (b == 8'h81) begin
                    if (m >= 6) begin
                        r.immediate = imm32_at(h + 2);
                        r.kind = K_GRP1I32;
                        r.inst_length = 4'(h + 6);
                        return h + 6;
                    end else if (!fin) return -1;
                end else if (b == 8'h83 || b == 8'hC1) begin
                    if (m >= 3) begin
                        r.immediate = (b == 8'h83) ? {{56{win[h+2][7]}}, win[h+2]}
                                                   : {56'd0, win[h+2]};
                        r.kind = (b == 8'h83) ? K_GRP1I8 : K_SHIFT;
                        r.inst_length = 4'(h + 3);
                        return h + 3;
                    end else if (!fin) return -1;
                end else if (b == 8'hF7) begin
                    r.kind = (reg_n == 4'd3) ? K_NEG : ((reg_n == 4'd7) ? K_IDIV : K_F7OTH);
                    return h + 2;
                end else if (b == 8'hFF) begin
                    r.kind = (reg_n == 4'd2) ? K_CALLRM :
                             ((reg_n == 4'd6) ? K_PUSHRM : K_FFOTH);
                    return h + 2;
                end
                r = '0;
            end
        end

        if (b == 8'h99 && rw) begin
            r.kind = K_CQO; r.inst_length = 4'(h + 1); return h + 1;
        end

        if (b >= 8'hB9 && b <= 8'hBF && rw) begin
            if (m >= 9) begin
                r.dest_reg = {1'b0, b[2:0]} | bx;
                r.immediate = imm64_at(h + 1);
                r.kind = K_MOVABS;
                r.inst_length = 4'(h + 9);
                return h + 9;
            end else if (!fin) return -1;
        end

        r = '0;
        r.immediate = {56'd0, b};
        r.kind = K_DB;
        r.inst_length = 4'(h + 1);
        return h + 1;
    endfunction

    task automatic predict_records(logic [7:0] code, logic fin);
        int    k;
        int    count;
        t_rec  r;
        t_item it;
        count = 0;
        if (win_fill >= 16) win_fill = 0;
        win[win_fill] = code;
        win_fill++;
        while (win_fill > 0 && count < 10) begin
            k = decode_insn(win_fill, fin, r);
            if (k < 0) break;
            if (k == 0 || k > win_fill) begin
                win_fill = 0;
                break;
            end
            it.rec = r;
            it.start_offset = code_off[15:0];
            it.flush_last = 1'b0;
            expected_recs.push_back(it);
            count++;
            code_off = (code_off + k) % CODE_SPAN;
            for (int i = 0; i + k < win_fill; i++) win[i] = win[i+k];
            win_fill -= k;
        end
        if (fin) begin
            win_fill = 0;
            code_off = 0;
        end
        if (count > 0) begin
            it = expected_recs.pop_back();
            it.flush_last = 1'b1;
            expected_recs.push_back(it);
        end
    endtask

    function automatic int sender_idle_pct();
        if (in_count < total_bytes / 3) return 32;
        if (in_count < 2 * total_bytes / 3) return 53;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (in_count < total_bytes / 3) return 53;
        if (in_count < 2 * total_bytes / 3) return 32;
        return 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_records(i_code_byte, i_end_of_code);
                in_count <= in_count + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pend_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    i_in_valid <= 1'b1;
                    i_code_byte <= pend_bytes[0].code;
                    i_end_of_code <= pend_bytes[0].eoc;
                    pend_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_item e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_recs.size() == 0) begin
                    $error("record transfer with nothing expected");
                    errors++;
                end else begin
                    e = expected_recs.pop_front();
                    check_field("kind", 64'(e.rec.kind), 64'(o_kind));
                    check_field("sub_op", 64'(e.rec.sub_op), 64'(o_sub_op));
                    check_field("dest_reg", 64'(e.rec.dest_reg), 64'(o_dest_reg));
                    check_field("src_reg", 64'(e.rec.src_reg), 64'(o_src_reg));
                    check_field("immediate", e.rec.immediate, o_immediate);
                    check_field("inst_length", 64'(e.rec.inst_length), 64'(o_inst_length));
                    check_field("start_offset", 64'(e.start_offset), 64'(o_start_offset));
                    check_field("flush_last", 64'(e.flush_last), 64'(o_flush_last));
                end
            end
            i_out_ready <= !hold && ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    task automatic push_byte(logic [7:0] code, logic eoc);
        byte_xfer_t x;
        x.code = code;
        x.eoc = eoc;
        pend_bytes.push_back(x);
    endtask

    task automatic push_seq(logic [7:0] s[$], logic eoc);
        foreach (s[i]) push_byte(s[i], eoc && (i == s.size() - 1));
    endtask

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] rnd_modrm();
        if ($urandom_range(9) < 8) return {2'b11, 6'($urandom_range(63))};
        return rnd_byte();
    endfunction

    task automatic push_rand_insn();
        logic [7:0] s[$];
        int         form;
        int         cut;
        logic [7:0] ops[7] = '{8'h89, 8'h8B, 8'h01, 8'h29, 8'h31, 8'h39, 8'h85};
        s = {};
        form = $urandom_range(14);
        if (form != 3 && form != 11 && form != 12 && $urandom_range(1))
            s.push_back(8'h40 | 8'($urandom_range(15)));
        case (form)
            0: s.push_back(8'hC3);
            1: s.push_back(8'h50 + 8'($urandom_range(15)));
            2: begin
                s.push_back($urandom_range(1) ? 8'hE9 : 8'hE8);
                repeat (4) s.push_back(rnd_byte());
            end
            3, 12: begin
                s.push_back(8'h48 | 8'($urandom_range(7)));
                s.push_back(form == 3 ? 8'hB8 : 8'hB9 + 8'($urandom_range(6)));
                repeat (8) s.push_back(rnd_byte());
            end
            4: begin
                s.push_back(8'hC7);
                s.push_back($urandom_range(3) ? {5'b11000, 3'($urandom_range(7))}
                                              : rnd_modrm());
                repeat (4) s.push_back(rnd_byte());
            end
            5: begin
                s.push_back(8'h0F);
                s.push_back(8'h80 + 8'($urandom_range(15)));
                repeat (4) s.push_back(rnd_byte());
            end
            6: begin
                s.push_back(8'h0F);
                s.push_back(8'hAF);
                s.push_back(rnd_byte());
            end
            7: begin
                s.push_back($urandom_range(9) ? ops[$urandom_range(6)] : 8'h8D);
                s.push_back(rnd_modrm());
            end
            8: begin
                s.push_back(8'h81);
                s.push_back(rnd_modrm());
                repeat (4) s.push_back(rnd_byte());
            end
            9: begin
                s.push_back($urandom_range(1) ? 8'h83 : 8'hC1);
                s.push_back(rnd_modrm());
                s.push_back(rnd_byte());
            end
            10: begin
                s.push_back($urandom_range(1) ? 8'hF7 : 8'hFF);
                s.push_back(rnd_modrm());
            end
            11: begin
                s.push_back(8'h48 | 8'($urandom_range(7)));
                s.push_back(8'h99);
            end
            default: s.push_back(rnd_byte());
        endcase
        cut = $urandom_range(99);
        if (cut < 5) begin
            s = s[0:$urandom_range(s.size() - 1)];
            push_seq(s, 1'b1);
        end else begin
            push_seq(s, cut < 13);
        end
    endtask

    initial begin
        // directed: extremes, truncation at end of code, drops, REX push/pop
        push_seq('{8'hC3, 8'h50, 8'h5F, 8'h41, 8'h57, 8'h49, 8'h58}, 1'b0);
        push_seq('{8'hE9, 8'hFF, 8'hFF, 8'hFF, 8'h7F}, 1'b0);
        push_seq('{8'hE8, 8'h00, 8'h00, 8'h00, 8'h80}, 1'b0);
        push_seq('{8'h4F, 8'hB8, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        push_seq('{8'h4D, 8'h0F, 8'hAF, 8'hFF, 8'h89, 8'h00}, 1'b0);
        push_seq('{8'hE9, 8'h12}, 1'b1);
        push_seq('{8'h48}, 1'b1);
        push_seq('{8'h90, 8'h01}, 1'b1);
        push_seq('{8'h48, 8'h99, 8'h0F, 8'h85, 8'h00}, 1'b1);
        while (pend_bytes.size() < RAND_ITEMS) push_rand_insn();
        total_bytes = pend_bytes.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pend_bytes.size() > 0 || i_in_valid || expected_recs.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && expected_recs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // long receiver hold-off to back the decoder up into its input
    initial begin
        wait (in_count >= 70);
        @(posedge i_clk);
        hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: x86_64_subset_instruction_decoder.f
rtl/xdec_pkg.sv
rtl/xdec_front.sv
rtl/xdec_fifo.sv
rtl/xdec_back.sv
rtl/x86_64_subset_instruction_decoder.sv
test/tb_top.sv
